@@ src/cci_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cci_pkg: shared types and constants for the cluster cell index block
// Request layouts, register map and grid limits.
// ----------------------------------------------------------------------------
package cci_pkg;

  // Grid limits
  localparam int MAX_SLICES = 256;
  localparam int MAX_TILE   = 4096;
  localparam int SLICE_W    = $clog2(MAX_SLICES);

  // Register map (byte address = 4 * index)
  localparam int REG_ADDR_W = 5;
  localparam logic [2:0] REG_TILE_SIZE   = 3'd0;
  localparam logic [2:0] REG_VIEW_WIDTH  = 3'd1;
  localparam logic [2:0] REG_VIEW_HEIGHT = 3'd2;
  localparam logic [2:0] REG_SLICE_COUNT = 3'd3;
  localparam logic [2:0] REG_ORTHO_MODE  = 3'd4;
  localparam logic [2:0] REG_DEPTH_NEAR  = 3'd5;
  localparam logic [2:0] REG_DEPTH_FAR   = 3'd6;
  localparam logic [2:0] REG_DEPTH_SCALE = 3'd7;

  // Reset values
  localparam logic [12:0] RST_TILE_SIZE   = 13'd16;
  localparam logic [15:0] RST_VIEW_WIDTH  = 16'd1920;
  localparam logic [15:0] RST_VIEW_HEIGHT = 16'd1080;
  localparam logic [8:0]  RST_SLICE_COUNT = 9'd16;
  localparam logic        RST_ORTHO_MODE  = 1'b0;
  localparam logic [31:0] RST_DEPTH_NEAR  = 32'd6554;
  localparam logic [31:0] RST_DEPTH_FAR   = 32'd65536000;
  localparam logic [31:0] RST_DEPTH_SCALE = 32'd65536;

  typedef struct packed {
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [31:0] view_depth;
  } in_req_t;

  typedef struct packed {
    logic [31:0] cell_index;
    logic        index_valid;
  } out_req_t;

endpackage
`default_nettype wire

@@ src/cluster_cell_index_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cluster_cell_index_core: light-grid cell lookup for clustered shading
// Maps pixel position and view depth to a flat slice/row/column cell index.
// ----------------------------------------------------------------------------
// One request per clock while the output is not stalled. A 64-step restoring
// divider forms the depth/near ratio for the logarithmic slice, followed by 16
// registered squaring steps of the log2 mantissa and the two index multiplies.
// Tile coordinates and grid size come from four 17-step dividers running
// alongside. The last stage is the output register; a stalled output holds the
// whole pipeline, and new requests are taken whenever the output register is
// empty or being drained. Registers must only be written while no request is
// in flight.
module cluster_cell_index_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cci_pkg::REG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  cci_pkg::in_req_t                in_req,
  output logic                            out_valid,
  input  logic                            out_ready,
  output cci_pkg::out_req_t               out_req
);
  import cci_pkg::*;

  // Stage map
  localparam int DIV_LAST  = 64;
  localparam int TDIV_LAST = 17;
  localparam int LIN_DIFF  = 1;
  localparam int LIN_MUL   = 2;
  localparam int MSB_ST    = 65;
  localparam int NORM_ST   = 66;
  localparam int SQ_FIRST  = 67;
  localparam int SQ_LAST   = 82;
  localparam int SCALE_ST  = 83;
  localparam int CLAMP_ST  = 84;
  localparam int ROWS_ST   = 85;
  localparam int ADDROW_ST = 86;
  localparam int COLS_ST   = 87;
  localparam int LAST_ST   = 88;

  typedef struct packed {
    logic                  vld;
    logic                  ok;
    logic [31:0]           dsh;   // dividend bits still to shift in
    logic [31:0]           rem;
    logic [63:0]           quo;   // Q32.32 ratio
    logic [3:0][12:0]      trem;  // tile divider remainders
    logic [3:0][16:0]      tdq;   // x, y, cols, rows: dividend then quotient
    logic [31:0]           lin;   // depth diff, then raw slice
    logic [5:0]            msb;
    logic [31:0]           mant;  // Q1.31
    logic [20:0]           logv;  // Q5.16
    logic [SLICE_W-1:0]    slice;
    logic [31:0]           acc;
  } stage_t;

  // Configuration registers
  logic [12:0] tile_size;
  logic [15:0] view_width;
  logic [15:0] view_height;
  logic [8:0]  slice_count;
  logic        ortho_mode;
  logic [31:0] depth_near;
  logic [31:0] depth_far;
  logic [31:0] depth_scale;

  logic [2:0] reg_sel;
  assign reg_sel = paddr[REG_ADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_size   <= RST_TILE_SIZE;
      view_width  <= RST_VIEW_WIDTH;
      view_height <= RST_VIEW_HEIGHT;
      slice_count <= RST_SLICE_COUNT;
      ortho_mode  <= RST_ORTHO_MODE;
      depth_near  <= RST_DEPTH_NEAR;
      depth_far   <= RST_DEPTH_FAR;
      depth_scale <= RST_DEPTH_SCALE;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_TILE_SIZE:   tile_size   <= pwdata[12:0];
        REG_VIEW_WIDTH:  view_width  <= pwdata[15:0];
        REG_VIEW_HEIGHT: view_height <= pwdata[15:0];
        REG_SLICE_COUNT: slice_count <= pwdata[8:0];
        REG_ORTHO_MODE:  ortho_mode  <= pwdata[0];
        REG_DEPTH_NEAR:  depth_near  <= pwdata;
        REG_DEPTH_FAR:   depth_far   <= pwdata;
        REG_DEPTH_SCALE: depth_scale <= pwdata;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_sel)
      REG_TILE_SIZE:   prdata = 32'(tile_size);
      REG_VIEW_WIDTH:  prdata = 32'(view_width);
      REG_VIEW_HEIGHT: prdata = 32'(view_height);
      REG_SLICE_COUNT: prdata = 32'(slice_count);
      REG_ORTHO_MODE:  prdata = 32'(ortho_mode);
      REG_DEPTH_NEAR:  prdata = depth_near;
      REG_DEPTH_FAR:   prdata = depth_far;
      REG_DEPTH_SCALE: prdata = depth_scale;
    endcase
  end

  stage_t st  [0:LAST_ST];
  stage_t nxt [0:LAST_ST];
  logic   adv;

  // Global advance: move while the output register is empty or drained
  assign adv      = ~st[LAST_ST].vld | out_ready;
  assign in_ready = adv;

  // Entry stage: range checks and divider setup
  always_comb begin : c_entry
    logic bad_grid;
    bad_grid = (tile_size == 13'd0) || (tile_size > 13'(MAX_TILE)) ||
               (slice_count == 9'd0) || (slice_count > 9'(MAX_SLICES));
    nxt[0]        = '0;
    nxt[0].vld    = in_valid;
    nxt[0].ok     = !bad_grid &&
                    (in_req.pixel_x < view_width) && (in_req.pixel_y < view_height) &&
                    (in_req.view_depth >= depth_near) && (in_req.view_depth <= depth_far) &&
                    (ortho_mode || (depth_near != 32'd0));
    nxt[0].dsh    = in_req.view_depth;
    nxt[0].tdq[0] = {1'b0, in_req.pixel_x};
    nxt[0].tdq[1] = {1'b0, in_req.pixel_y};
    nxt[0].tdq[2] = 17'(view_width) + 17'(tile_size) - 17'd1;
    nxt[0].tdq[3] = 17'(view_height) + 17'(tile_size) - 17'd1;
  end

  // Pipeline stages
  for (genvar k = 1; k <= LAST_ST; k++) begin : g_st
    always_comb begin : c_step
      logic [32:0]        trial;
      logic [13:0]        ttrial;
      logic [63:0]        prod;
      logic [52:0]        lprod;
      logic [32:0]        sq;
      logic [8:0]         last;
      trial  = '0;
      ttrial = '0;
      prod   = '0;
      lprod  = '0;
      sq     = '0;
      last   = '0;
      nxt[k] = st[k-1];

      // Ratio divider: one quotient bit per stage
      if (k <= DIV_LAST) begin
        trial      = {st[k-1].rem, st[k-1].dsh[31]};
        nxt[k].dsh = {st[k-1].dsh[30:0], 1'b0};
        if (trial >= {1'b0, depth_near}) begin
          nxt[k].rem = 32'(trial - {1'b0, depth_near});
          nxt[k].quo = {st[k-1].quo[62:0], 1'b1};
        end else begin
          nxt[k].rem = trial[31:0];
          nxt[k].quo = {st[k-1].quo[62:0], 1'b0};
        end
      end

      // Tile dividers: x, y, columns, rows
      if (k <= TDIV_LAST) begin
        for (int j = 0; j < 4; j++) begin
          ttrial = {st[k-1].trem[j], st[k-1].tdq[j][16]};
          if (ttrial >= {1'b0, tile_size}) begin
            nxt[k].trem[j] = 13'(ttrial - {1'b0, tile_size});
            nxt[k].tdq[j]  = {st[k-1].tdq[j][15:0], 1'b1};
          end else begin
            nxt[k].trem[j] = ttrial[12:0];
            nxt[k].tdq[j]  = {st[k-1].tdq[j][15:0], 1'b0};
          end
        end
      end

      // Linear slice: difference, then product with scale
      if (k == LIN_DIFF) begin
        nxt[k].lin = st[k-1].dsh - depth_near;
      end
      if (k == LIN_MUL) begin
        prod       = 64'(st[k-1].lin) * 64'(depth_scale);
        nxt[k].lin = prod[63:32];
      end

      // Leading one of the ratio
      if (k == MSB_ST) begin
        for (int i = 0; i < 64; i++) begin
          if (st[k-1].quo[i]) nxt[k].msb = 6'(i);
        end
      end

      // Normalize to Q1.31, integer part of log
      if (k == NORM_ST) begin
        nxt[k].mant = 32'(st[k-1].quo >> (st[k-1].msb - 6'd31));
        nxt[k].logv = {5'(st[k-1].msb - 6'd32), 16'd0};
      end

      // One fraction bit per squaring
      if (k >= SQ_FIRST && k <= SQ_LAST) begin
        prod = 64'(st[k-1].mant) * 64'(st[k-1].mant);
        sq   = prod[63:31];
        if (sq[32]) begin
          nxt[k].mant                  = sq[32:1];
          nxt[k].logv[5'(SQ_LAST - k)] = 1'b1;
        end else begin
          nxt[k].mant = sq[31:0];
        end
      end

      // Log slice, picked over linear in perspective mode
      if (k == SCALE_ST) begin
        lprod = 53'(st[k-1].logv) * 53'(depth_scale);
        if (!ortho_mode) nxt[k].lin = 32'(lprod[52:32]);
      end

      // Clamp to last slice
      if (k == CLAMP_ST) begin
        last = slice_count - 9'd1;
        if (st[k-1].lin > 32'(last)) nxt[k].slice = last[SLICE_W-1:0];
        else                         nxt[k].slice = st[k-1].lin[SLICE_W-1:0];
      end

      // Flat index: (slice * rows + ty) * cols + tx
      if (k == ROWS_ST) begin
        nxt[k].acc = 32'(24'(st[k-1].slice) * 24'(st[k-1].tdq[3][15:0]));
      end
      if (k == ADDROW_ST) begin
        nxt[k].acc = st[k-1].acc + 32'(st[k-1].tdq[1][15:0]);
      end
      if (k == COLS_ST) begin
        nxt[k].acc = 32'(st[k-1].acc * 32'(st[k-1].tdq[2][15:0]));
      end
      if (k == LAST_ST) begin
        nxt[k].acc = st[k-1].acc + 32'(st[k-1].tdq[0][15:0]);
      end
    end
  end

  // Stage registers; only valid bits are reset
  for (genvar k = 0; k <= LAST_ST; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (rst) begin
        st[k].vld <= 1'b0;
      end else if (adv) begin
        st[k] <= nxt[k];
      end
    end
  end

  // Output register is the last stage
  assign out_valid           = st[LAST_ST].vld;
  assign out_req.index_valid = st[LAST_ST].ok;
  assign out_req.cell_index  = st[LAST_ST].ok ? st[LAST_ST].acc : '1;

endmodule
`default_nettype wire

@@ src/cci_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cci_checker: port-level checks for the cluster cell index block
// Watches handshake and result encoding on the top-level ports.
// ----------------------------------------------------------------------------
module cci_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cci_pkg::REG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  input  logic [31:0]                     prdata,
  input  logic                            pready,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  cci_pkg::in_req_t                in_req,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  cci_pkg::out_req_t               out_req
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_req))
    else $error("stalled result changed");

  // Invalid result carries an all-ones index
  a_inv_ones: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_req.index_valid |-> out_req.cell_index == 32'hFFFF_FFFF)
    else $error("invalid result without all-ones index");

  // Input side takes requests exactly when the output side can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  // Reset flushes the pipeline
  a_flush: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind cluster_cell_index_core cci_checker u_cci_checker (.*);
`default_nettype wire

@@ sim/cluster_cell_index_core_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cluster_cell_index_core_tb: self-checking bench for the cell index core
// Drives pixel/depth requests with random gaps, predicts each cell index in
// Q16.16 fixed point and compares every output request in order.
// ----------------------------------------------------------------------------
module cluster_cell_index_core_tb;
  import cci_pkg::*;

  localparam int LATENCY    = 89;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [REG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  in_req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_req_t out_req;

  cluster_cell_index_core DUT (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_req(out_req)
  );

  always #5 clk = ~clk;

  // Shadow copy of the grid setup
  logic [12:0] tile_q;
  logic [15:0] width_q, height_q;
  logic [8:0] slices_q;
  logic ortho_q;
  logic [31:0] near_q, far_q, scale_q;

  out_req_t cell_fifo[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stall_on = 1'b1;

  task automatic report_mismatch(input string what, input out_req_t got,
                                 input out_req_t want);
    $display("ERROR %s: got idx=%h v=%b want idx=%h v=%b at %0t", what,
             got.cell_index, got.index_valid, want.cell_index, want.index_valid,
             $realtime);
    errors++;
  endtask

  // log2 of a Q32.32 ratio >= 1, Q5.16
  function automatic logic [63:0] log2_q16(input logic [63:0] ratio);
    int msb;
    logic [63:0] res, m;
    msb = 63;
    while (msb > 0 && !ratio[msb]) msb--;
    res = 64'(msb - 32) << 16;
    m = ratio >> (msb - 31);
    for (int b = 15; b >= 0; b--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        res[b] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic out_req_t predict_cell(input in_req_t r);
    out_req_t o;
    logic [63:0] z, slice, cols, rows, idx, d;
    o.cell_index = '1;
    o.index_valid = 1'b0;
    d = r.view_depth;
    if (tile_q == 0 || tile_q > MAX_TILE || slices_q == 0 || slices_q > MAX_SLICES ||
        r.pixel_x >= width_q || r.pixel_y >= height_q ||
        r.view_depth < near_q || r.view_depth > far_q)
      return o;
    if (ortho_q) begin
      z = (d - near_q) * scale_q;
    end else begin
      if (near_q == 0) return o;
      z = log2_q16((d << 32) / near_q) * scale_q;
    end
    slice = z >> 32;
    if (slice > slices_q - 1) slice = slices_q - 1;
    cols = (64'(width_q) + tile_q - 1) / tile_q;
    rows = (64'(height_q) + tile_q - 1) / tile_q;
    idx = (slice * rows + r.pixel_y / tile_q) * cols + r.pixel_x / tile_q;
    o.cell_index = idx[31:0];
    o.index_valid = 1'b1;
    return o;
  endfunction

  // Register write: setup then access phase; psel stays up between writes
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= REG_ADDR_W'(idx) << 2; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    case (idx)
      REG_TILE_SIZE:   tile_q = val[12:0];
      REG_VIEW_WIDTH:  width_q = val[15:0];
      REG_VIEW_HEIGHT: height_q = val[15:0];
      REG_SLICE_COUNT: slices_q = val[8:0];
      REG_ORTHO_MODE:  ortho_q = val[0];
      REG_DEPTH_NEAR:  near_q = val;
      REG_DEPTH_FAR:   far_q = val;
      REG_DEPTH_SCALE: scale_q = val;
      default: ;
    endcase
  endtask

  task automatic setup_grid(input int t, input int w, input int h, input int s,
                            input bit o, input logic [31:0] n, input logic [31:0] f,
                            input logic [31:0] sc);
    write_reg(REG_TILE_SIZE, t);
    write_reg(REG_VIEW_WIDTH, w);
    write_reg(REG_VIEW_HEIGHT, h);
    write_reg(REG_SLICE_COUNT, s);
    write_reg(REG_ORTHO_MODE, 32'(o));
    write_reg(REG_DEPTH_NEAR, n);
    write_reg(REG_DEPTH_FAR, f);
    write_reg(REG_DEPTH_SCALE, sc);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 5) return $urandom_range(10, 60);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // Send one request, optionally with a preceding idle gap; valid stays up
  // after acceptance so back-to-back requests need no second assignment
  task automatic send_sample(input in_req_t r, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_req <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    cell_fifo = {cell_fifo, predict_cell(r)};
    @(negedge clk);
  endtask

  // Drain everything, then let the pipeline settle
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (cell_fifo.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  function automatic in_req_t rand_sample(input int near_bias);
    in_req_t r;
    r.pixel_x = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                16'($urandom_range(0, (width_q == 0) ? 0 : width_q - 1));
    r.pixel_y = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                16'($urandom_range(0, (height_q == 0) ? 0 : height_q - 1));
    if ($urandom_range(0, 9) == 0 || far_q < near_q) r.view_depth = $urandom;
    else r.view_depth = near_q + 32'($urandom_range(0, far_q - near_q));
    if (near_bias != 0 && $urandom_range(0, 7) == 0) r.view_depth = near_q;
    return r;
  endfunction

  // Output side: random stalls and in-order compare
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_on = ~stall_on;
    if (!stall_on) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 99) < 8) ? 1'b0 : ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (cell_fifo.size() == 0) begin
        report_mismatch("unexpected request", out_req, '0);
      end else begin
        if (out_req.cell_index !== cell_fifo[0].cell_index ||
            out_req.index_valid !== cell_fifo[0].index_valid)
          report_mismatch("cell", out_req, cell_fifo[0]);
        void'(cell_fifo.pop_front());
      end
    end
  end

  // Watchdog on accepted traffic
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("cluster_cell_index_core: mismatch");
      $finish;
    end
  end

  // Directed rows: expected typed in where obvious, else predicted
  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] d;
    bit typed;
    logic [31:0] idx;
    logic v;
  } probe_row_t;

  probe_row_t probes[] = '{
    '{16'd0, 16'd0, 32'd6554, 1'b1, 32'd0, 1'b1},
    '{16'd1919, 16'd1079, 32'd6554, 1'b1, 32'd8159, 1'b1},
    '{16'd1920, 16'd0, 32'd65536, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{16'd0, 16'd1080, 32'd65536, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{16'd0, 16'd0, 32'd6553, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{16'd0, 16'd0, 32'd65536001, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{16'd0, 16'd0, 32'd65536000, 1'b0, 32'd0, 1'b0},
    '{16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{16'd100, 16'd200, 32'd13108, 1'b0, 32'd0, 1'b0},
    '{16'd777, 16'd555, 32'd655360, 1'b0, 32'd0, 1'b0},
    '{16'd5, 16'd6, 32'd0, 1'b1, 32'hFFFF_FFFF, 1'b0}
  };

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) send_sample(rand_sample(1), 1'b1);
  endtask

  initial begin
    in_req_t r;
    out_req_t want;
    tile_q = RST_TILE_SIZE; width_q = RST_VIEW_WIDTH; height_q = RST_VIEW_HEIGHT;
    slices_q = RST_SLICE_COUNT; ortho_q = RST_ORTHO_MODE; near_q = RST_DEPTH_NEAR;
    far_q = RST_DEPTH_FAR; scale_q = RST_DEPTH_SCALE;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table against reset setup
    foreach (probes[i]) begin
      r.pixel_x = probes[i].x; r.pixel_y = probes[i].y; r.view_depth = probes[i].d;
      want = predict_cell(r);
      if (probes[i].typed && (want.cell_index !== probes[i].idx ||
                              want.index_valid !== probes[i].v))
        report_mismatch("table row", want, '{probes[i].idx, probes[i].v});
      send_sample(r, 1'b0);
    end
    drain_pipe();

    // Ortho, extreme scale, tile 1; one slice, zero scale; wrap
    setup_grid(1, 65535, 65535, 256, 1'b1, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    r = '{16'hFFFE, 16'hFFFE, 32'hFFFF_FFFF}; send_sample(r, 1'b0);
    r = '{16'd0, 16'd0, 32'd1}; send_sample(r, 1'b0);
    run_random(150);
    drain_pipe();
    setup_grid(4096, 1, 1, 1, 1'b0, 32'd65536, 32'hFFFF_FFFF, 32'd0);
    r = '{16'd0, 16'd0, 32'hFFFF_FFFF}; send_sample(r, 1'b0);
    run_random(50);
    drain_pipe();
    // Bad setup and zero near in log mode
    setup_grid(0, 640, 480, 0, 1'b0, 32'd0, 32'd100, 32'd65536);
    run_random(20);
    drain_pipe();
    setup_grid(4097, 640, 480, 257, 1'b0, 32'd0, 32'd1000000, 32'd65536);
    run_random(20);
    drain_pipe();
    setup_grid(8, 640, 480, 32, 1'b0, 32'd0, 32'd1000000, 32'd65536);
    run_random(20);
    drain_pipe();
    // far below near
    setup_grid(16, 640, 480, 32, 1'b1, 32'd500000, 32'd400000, 32'd65536);
    run_random(20);
    drain_pipe();

    // Random setups
    for (int p = 0; p < 8; p++) begin
      setup_grid($urandom_range(1, 64), $urandom_range(1, 4000), $urandom_range(1, 4000),
                 $urandom_range(1, 256), 1'($urandom_range(0, 1)),
                 $urandom_range(1, 1 << 20),
                 $urandom_range(1 << 21, 32'hFFFF_FFFF), $urandom);
      run_random(115);
      drain_pipe();
    end

    if (errors == 0) begin
      $display("cluster_cell_index_core: match");
    end else begin
      $display("cluster_cell_index_core: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
src/cci_pkg.sv
src/cluster_cell_index_core.sv
src/cci_checker.sv
sim/cluster_cell_index_core_tb.sv
